FILE: rtl/lbmt_pkg.sv
package lbmt_pkg;
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned PortsDef        = 8;
  localparam int unsigned TimeBitsDef     = 16;
  localparam int unsigned MaxAgeReset     = 300;
  localparam int unsigned PortCountReset  = 8;
  localparam int unsigned MacW            = 48;
  localparam int unsigned PortW           = 3;

  localparam logic [1:0] DecForward = 2'd0;
  localparam logic [1:0] DecFlood   = 2'd1;
  localparam logic [1:0] DecFilter  = 2'd2;
  localparam logic [1:0] DecTick    = 2'd3;

  localparam logic CfgPortCount = 1'b0;
  localparam logic CfgMaxAge    = 1'b1;
endpackage

FILE: rtl/learning_bridge_mac_table_core.sv
// Learning bridge forwarding table with aging.
// Slave stream s_axis: one item per transfer. tuser = mode (0 frame, 1 tick).
// tdata = {ingress_port, dest_mac, source_mac}, source_mac in the low bits.
// Master stream m_axis: one result per item; tdata = {aged_count, table_full,
// station_moved, source_learned, decision, egress_mask}, mask lowest.
// Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i write port_count (0) and
// max_age (1); write only while idle.
// A frame walks the table one entry per cycle from a memory with one read
// and one write port (MAC, port, last-seen), comparing both addresses and
// tracking the first free slot, then writes the source entry unless the table
// is full. A tick walks it likewise and clears each expired entry's valid bit.
// Either way the result is registered after the scan, last and learn states.
// The table walk sets the rate; one item is in flight at a time.
// Reset clears all valid bits (flip-flops), the seconds counter and the
// registers; no clearing pass is needed. The result sits in an output
// register until taken; a new item is taken only after that, so a stalled
// sink delays the next input transfer.
module learning_bridge_mac_table_core
  import lbmt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned PORTS         = PortsDef,
  parameter int unsigned TIME_BITS     = TimeBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] source_mac, [95:48] dest_mac, [98:96] ingress_port, zero fill
  input  logic [103:0] s_axis_tdata,
  // [0] mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] egress_mask, [9:8] decision, [10] source_learned,
  // [11] station_moved, [12] table_full, [19:13] aged_count, zero fill
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [14:0]  cfg_wdata_i
);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {
    StIdle, StScan, StLast, StLearn, StOut
  } state_e;

  typedef struct packed {
    logic [MacW-1:0]      mac;
    logic [PortW-1:0]     port;
    logic [TIME_BITS-1:0] seen;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  state_e state_q;
  logic [CW-1:0] idx_q;      // read address counter
  logic [AW-1:0] cmp_idx_q;  // entry whose data is in rd_q
  logic          cmp_v_q;
  logic          mode_q;
  logic [MacW-1:0]  src_q, dst_q;
  logic [PortW-1:0] ing_q;
  logic          dfound_q, sfound_q, ffound_q;
  logic [PortW-1:0] dport_q, sport_q;
  logic [AW-1:0] sidx_q, fidx_q;
  logic [6:0]    aged_q;
  logic [TIME_BITS-1:0] now_q;
  logic [3:0]    port_cnt_q;
  logic [14:0]   max_age_q;
  logic [23:0]   out_q;
  logic          out_v_q;

  // age compare
  logic [TIME_BITS-1:0] age;
  logic                 too_old;
  assign age = now_q - rd_q.seen;
  always_comb begin
    if (TIME_BITS > 15) too_old = age > TIME_BITS'(max_age_q);
    else too_old = {{(32-TIME_BITS){1'b0}}, age} > {17'd0, max_age_q};
  end

  logic [3:0] pc;
  always_comb begin
    pc = port_cnt_q;
    if (pc == 4'd0) pc = 4'd1;
    if (pc > 4'(PORTS)) pc = 4'(PORTS);
  end

  logic [7:0] flood_mask;
  assign flood_mask = 8'((9'd1 << pc) - 9'd1) & ~(8'd1 << ing_q);

  logic cur_valid;
  assign cur_valid = valid_q[cmp_idx_q];

  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  always_comb begin
    mem_we = (state_q == StLearn) && !mode_q && (sfound_q || ffound_q);
    mem_wa = sfound_q ? sidx_q : fidx_q;
    mem_wd.mac  = src_q;
    mem_wd.port = ing_q;
    mem_wd.seen = now_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      valid_q    <= '0;
      idx_q      <= '0;
      cmp_idx_q  <= '0;
      cmp_v_q    <= 1'b0;
      now_q      <= '0;
      port_cnt_q <= 4'(PortCountReset);
      max_age_q  <= 15'(MaxAgeReset);
      out_v_q    <= 1'b0;
      out_q      <= '0;
      mode_q     <= 1'b0;
      src_q      <= '0;
      dst_q      <= '0;
      ing_q      <= '0;
      dfound_q   <= 1'b0;
      sfound_q   <= 1'b0;
      ffound_q   <= 1'b0;
      dport_q    <= '0;
      sport_q    <= '0;
      sidx_q     <= '0;
      fidx_q     <= '0;
      aged_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPortCount: port_cnt_q <= cfg_wdata_i[3:0];
          CfgMaxAge:    max_age_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;

      // compare stage, shared by scan states
      if (cmp_v_q) begin
        if (mode_q) begin
          if (cur_valid && too_old) begin
            valid_q[cmp_idx_q] <= 1'b0;
            if (aged_q != 7'd127) aged_q <= aged_q + 7'd1;
          end
        end else if (cur_valid) begin
          if (!dfound_q && rd_q.mac == dst_q) begin
            dfound_q <= 1'b1;
            dport_q  <= rd_q.port;
          end
          if (!sfound_q && rd_q.mac == src_q) begin
            sfound_q <= 1'b1;
            sport_q  <= rd_q.port;
            sidx_q   <= cmp_idx_q;
          end
        end else if (!ffound_q) begin
          ffound_q <= 1'b1;
          fidx_q   <= cmp_idx_q;
        end
      end

      unique case (state_q)
        StIdle: begin
          cmp_v_q <= 1'b0;
          if (s_axis_tvalid && s_axis_tready) begin
            mode_q   <= s_axis_tuser;
            src_q    <= s_axis_tdata[47:0];
            dst_q    <= s_axis_tdata[95:48];
            ing_q    <= s_axis_tdata[98:96];
            dfound_q <= 1'b0;
            sfound_q <= 1'b0;
            ffound_q <= 1'b0;
            aged_q   <= '0;
            idx_q    <= '0;
            if (s_axis_tuser) now_q <= now_q + 1'b1;
            state_q  <= StScan;
          end
        end
        StScan: begin
          cmp_idx_q <= idx_q[AW-1:0];
          cmp_v_q   <= 1'b1;
          if (idx_q == CW'(TABLE_ENTRIES - 1)) state_q <= StLast;
          else idx_q <= idx_q + 1'b1;
        end
        StLast: begin
          cmp_v_q <= 1'b0;
          state_q <= StLearn;
        end
        StLearn: begin
          if (!mode_q) begin
            if (sfound_q) valid_q[sidx_q] <= 1'b1;
            else if (ffound_q) valid_q[fidx_q] <= 1'b1;
          end
          out_q <= '0;
          if (mode_q) begin
            out_q[9:8]   <= DecTick;
            out_q[19:13] <= aged_q;
          end else begin
            if (!dfound_q) begin
              out_q[7:0] <= flood_mask;
              out_q[9:8] <= DecFlood;
            end else if (dport_q != ing_q) begin
              out_q[7:0] <= 8'd1 << dport_q;
              out_q[9:8] <= DecForward;
            end else begin
              out_q[9:8] <= DecFilter;
            end
            out_q[10] <= !sfound_q && ffound_q;
            out_q[11] <= sfound_q && (sport_q != ing_q);
            out_q[12] <= !sfound_q && !ffound_q;
          end
          out_v_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // no item taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !out_v_q)
    else $error("accept while result pending");
  // a result appears only at the end of learn
  a_out_from_learn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q == StLearn))
    else $error("result without learn");
  // ticks never mark entries valid
  a_tick_no_learn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLearn && mode_q) |=> $countones(valid_q) <= $past($countones(valid_q)))
    else $error("tick set a valid bit");
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb
  import lbmt_pkg::*;
;

  localparam int unsigned Entries = 64;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [6:0] aged;
    logic       full;
    logic       moved;
    logic       learned;
    logic [1:0] decision;
    logic [7:0] mask;
  } fwd_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;  // [47:0] source_mac, [95:48] dest_mac, [98:96] ingress_port
  logic         s_axis_tuser;  // [0] mode
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [23:0]  m_axis_tdata;  // [7:0] mask, [9:8] decision, [10] learned, [11] moved,
                               // [12] full, [19:13] aged_count
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [14:0]  cfg_wdata_i;

  // bridge table shadow
  logic        tbl_valid [Entries];
  logic [47:0] tbl_mac   [Entries];
  logic [2:0]  tbl_port  [Entries];
  logic [15:0] tbl_seen  [Entries];
  logic [15:0] secs_now;
  logic [3:0]  cur_ports;
  logic [14:0] cur_max_age;

  fwd_result_t expected_q[$];
  int errors;
  int n_frames, n_ticks, n_results;
  longint cycles;
  bit     stall_on;
  logic [47:0] mac_pool[16];

  learning_bridge_mac_table_core u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[learning_bridge_mac_table_core] ERROR");
      $finish;
    end
  end

  function automatic int find_mac(logic [47:0] mac);
    for (int i = 0; i < Entries; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic fwd_result_t predict_forwarding(logic mode, logic [47:0] src,
                                                     logic [47:0] dst, logic [2:0] ing);
    fwd_result_t r;
    int d, s;
    int pc;
    r = '0;
    if (mode) begin
      secs_now = secs_now + 16'd1;
      for (int i = 0; i < Entries; i++)
        if (tbl_valid[i] && (16'(secs_now - tbl_seen[i]) > {1'b0, cur_max_age})) begin
          tbl_valid[i] = 1'b0;
          if (r.aged != 7'd127) r.aged = r.aged + 7'd1;
        end
      r.decision = DecTick;
    end else begin
      pc = cur_ports;
      if (pc < 1) pc = 1;
      if (pc > 8) pc = 8;
      d = find_mac(dst);
      if (d < 0) begin
        r.mask = 8'((9'(1) << pc) - 9'd1) & ~(8'd1 << ing);
        r.decision = DecFlood;
      end else if (tbl_port[d] != ing) begin
        r.mask = 8'd1 << tbl_port[d];
        r.decision = DecForward;
      end else begin
        r.decision = DecFilter;
      end
      s = find_mac(src);
      if (s < 0) begin
        for (int i = 0; i < Entries; i++)
          if (!tbl_valid[i]) begin
            s = i;
            break;
          end
        if (s < 0) r.full = 1'b1;
        else begin
          tbl_valid[s] = 1'b1;
          tbl_mac[s] = src;
          tbl_port[s] = ing;
          tbl_seen[s] = secs_now;
          r.learned = 1'b1;
        end
      end else begin
        if (tbl_port[s] != ing) begin
          tbl_port[s] = ing;
          r.moved = 1'b1;
        end
        tbl_seen[s] = secs_now;
      end
    end
    return r;
  endfunction

  task automatic random_gap();
    if (!stall_on) return;
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  // tvalid stays up after a transfer until the next item or an idle gap replaces it;
  // tready is low for the whole table walk, so nothing is taken twice
  task automatic send_item(logic mode, logic [47:0] src, logic [47:0] dst, logic [2:0] ing);
    random_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'd0, ing, dst, src};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_forwarding(mode, src, dst, ing));
    if (mode) n_ticks++;
    else n_frames++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Entries + 10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPortCount) cur_ports = val[3:0];
    else cur_max_age = val;
  endtask

  // result checker
  always @(posedge clk_i) begin
    fwd_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[19:0];
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.mask !== want.mask) begin
          $error("egress_mask exp %h got %h", want.mask, got.mask); errors++;
        end
        if (got.decision !== want.decision) begin
          $error("decision exp %0d got %0d", want.decision, got.decision); errors++;
        end
        if (got.learned !== want.learned) begin
          $error("source_learned exp %0d got %0d", want.learned, got.learned); errors++;
        end
        if (got.moved !== want.moved) begin
          $error("station_moved exp %0d got %0d", want.moved, got.moved); errors++;
        end
        if (got.full !== want.full) begin
          $error("table_full exp %0d got %0d", want.full, got.full); errors++;
        end
        if (got.aged !== want.aged) begin
          $error("aged_count exp %0d got %0d", want.aged, got.aged); errors++;
        end
        if (m_axis_tdata[23:20] !== 4'd0) begin
          $error("pad exp 0 got %h", m_axis_tdata[23:20]); errors++;
        end
      end
    end
  end

  // sink backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [47:0] rand_mac();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  function automatic logic [47:0] pool_mac();
    return mac_pool[$urandom_range(0, 15)];
  endfunction

  task automatic test_directed();
    send_item(1'b0, 48'h0, 48'hFFFF_FFFF_FFFF, 3'd0);
    send_item(1'b0, 48'hFFFF_FFFF_FFFF, 48'h0, 3'd7);
    send_item(1'b0, 48'h0, 48'hFFFF_FFFF_FFFF, 3'd7);   // filter, station moved
    send_item(1'b0, 48'hAAAA_5555_AAAA, 48'h0, 3'd7);   // known dest on ingress: filter
    send_item(1'b0, 48'h5555_AAAA_5555, 48'h5555_AAAA_5555, 3'd2);  // same src/dst
    send_item(1'b1, 48'h0, 48'h0, 3'd0);
    send_item(1'b1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd7);
  endtask

  task automatic test_port_count();
    logic [3:0] vals[4] = '{4'd0, 4'd1, 4'd15, 4'd3};
    foreach (vals[k]) begin
      write_reg(CfgPortCount, {11'd0, vals[k]});
      send_item(1'b0, rand_mac(), rand_mac(), 3'd6);       // ingress 6, outside all counts but 15
      send_item(1'b0, 48'hFFFF_FFFF_FFFF, rand_mac(), 3'd0); // random dest, known source now on port 0
    end
    write_reg(CfgPortCount, 15'd8);
  endtask

  task automatic test_aging();
    write_reg(CfgMaxAge, 15'd0);
    send_item(1'b0, 48'h1234, 48'h5678, 3'd1);
    send_item(1'b1, 48'h0, 48'h0, 3'd0);
    write_reg(CfgMaxAge, 15'd2);
    send_item(1'b0, 48'h1234, 48'h5678, 3'd1);
    repeat (4) send_item(1'b1, 48'h0, 48'h0, 3'd0);
    write_reg(CfgMaxAge, 15'd32767);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < Entries + 4; i++) send_item(1'b0, 48'hC0DE_0000_0000 + i, rand_mac(), 3'(i));
    write_reg(CfgMaxAge, 15'd0);
    send_item(1'b1, 48'h0, 48'h0, 3'd0);  // flush every entry
  endtask

  task automatic test_random(int count);
    logic [47:0] s, d;
    for (int i = 0; i < count; i++) begin
      if ((i % 200) == 0) begin
        write_reg(CfgPortCount, 15'($urandom_range(0, 15)));
        write_reg(CfgMaxAge, 15'($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                            : $urandom_range(1, 12)));
      end
      if (i > count - 150) stall_on = 1'b0;
      s = $urandom_range(0, 3) == 0 ? rand_mac() : pool_mac();
      d = $urandom_range(0, 3) == 0 ? rand_mac() : pool_mac();
      send_item($urandom_range(0, 7) == 0, s, d, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgPortCount;
    cfg_wdata_i = '0;
    errors = 0;
    cycles = 0;
    stall_on = 1'b1;
    for (int i = 0; i < Entries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i] = '0;
      tbl_port[i] = '0;
      tbl_seen[i] = '0;
    end
    for (int i = 0; i < 16; i++) mac_pool[i] = rand_mac();
    secs_now = '0;
    cur_ports = 4'(PortCountReset);
    cur_max_age = 15'(MaxAgeReset);
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_port_count();
    test_aging();
    test_table_full();
    test_random(1250);
    drain();

    $display("Covered %0d frames and %0d ticks, %0d results checked,", n_frames, n_ticks,
             n_results);
    $display("across port counts, age limits, table overflow and aging flushes.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[learning_bridge_mac_table_core] OK");
    end else begin
      $display("[learning_bridge_mac_table_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lbmt_pkg.sv
rtl/learning_bridge_mac_table_core.sv
sim/tb.sv
